// File: rtl/vsad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsad_pkg
// shared widths, register indexes, correction codes and pipeline control type
// for the vernier steering angle decoder
// ----------------------------------------------------------------------------
package vsad_pkg;

    // field widths
    localparam int DUTY_W    = 14;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int ANGLE_W   = 19;
    localparam int TURN_W    = 4;
    localparam int FIX_W     = 2;

    // number of register stages in the datapath
    localparam int PIPE_STAGES = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_TRIM       = 2'd2;

    // configuration reset values, 0.01 degree
    localparam logic [CFG_W-1:0] WINDOW_LIMIT_RST    = 15'd7000;
    localparam logic [CFG_W-1:0] CORRECTION_STEP_RST = 15'd12710;
    localparam logic [CFG_W-1:0] ZERO_TRIM_RST       = 15'd6000;

    // window correction codes
    localparam logic [FIX_W-1:0] FIX_NONE = 2'd0;
    localparam logic [FIX_W-1:0] FIX_SUB  = 2'd1;
    localparam logic [FIX_W-1:0] FIX_ADD  = 2'd2;

    // pipeline control handed from the stage controller to the datapath
    typedef struct packed {
        logic [PIPE_STAGES-1:0] load;
        logic [PIPE_STAGES-1:0] valid;
    } pipe_ctrl_t;

endpackage

// File: rtl/vsad_pipe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsad_pipe_ctrl
// valid bits and per-stage load enables for the elastic datapath; a stage
// loads when it is empty or when the stage after it moves on
// ----------------------------------------------------------------------------
module vsad_pipe_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  logic                down_ready,
    output vsad_pkg::pipe_ctrl_t ctrl
);
    import vsad_pkg::*;

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES:0]   take;

    always_comb
    begin
        take[PIPE_STAGES] = down_ready;
        for (int i = PIPE_STAGES - 1; i >= 0; i--)
        begin
            take[i] = !valid_reg[i] || take[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = take[0] ? up_valid : valid_reg[0];
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            valid_next[i] = take[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign up_ready   = take[0];
    assign ctrl.load  = take[PIPE_STAGES-1:0];
    assign ctrl.valid = valid_reg;

endmodule

// File: rtl/vernier_steering_angle_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vernier_steering_angle_decoder
// Decodes the two PWM duty cycles of a dual-gear (13/14 tooth) steering angle
// sensor into a multi-turn steering angle in 0.01 degree, the vernier turn
// index and a flag telling whether the window correction was applied. Duties
// are in 0.01 percent and saturate at 10000. The block is a twelve-stage
// pipeline with valid bits and a ready chain: it takes one duty pair per
// clock cycle while duty_ready is high, and each result passes the stage
// registers in order and is presented from the last. When the output is
// not taken, the stalled result holds and the empty stages in front of it
// keep filling, so input transactions continue until every stage is full.
// Throughput is one transaction per cycle while the output keeps up, set by
// the register stages of the datapath. The three divisions by constants (by
// 360000, by 17 and by 10) are reciprocal multiplies that each own a stage.
// Configuration registers (window limit, correction step, zero trim) are
// written through a plain write port and take effect for transactions that
// pass the stages reading them; write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
module vernier_steering_angle_decoder
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // duty pair channel
    input  logic                                  duty_valid,
    output logic                                  duty_ready,
    input  logic [vsad_pkg::DUTY_W-1:0]           duty_fine,
    input  logic [vsad_pkg::DUTY_W-1:0]           duty_coarse,
    // result channel
    output logic                                  angle_valid,
    input  logic                                  angle_ready,
    output logic signed [vsad_pkg::ANGLE_W-1:0]   steer_angle,
    output logic [vsad_pkg::TURN_W-1:0]           turn_index,
    output logic [vsad_pkg::FIX_W-1:0]            window_fix,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [vsad_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vsad_pkg::CFG_W-1:0]            cfg_wdata
);
    import vsad_pkg::*;

    // full scale duty
    localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;
    // reciprocals: floor(x/5625) for x < 2^17, floor(x/17) for x < 2^24,
    // floor(x/10) for x < 2^21
    localparam logic [19:0] RECIP_REV = 20'd763550;
    localparam logic [23:0] RECIP_17  = 24'd15790321;
    localparam logic [20:0] RECIP_10  = 21'd1677722;
    localparam logic [17:0] OUT_MAX   = 18'd140000;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] window_limit_reg;
    logic [CFG_W-1:0] correction_step_reg;
    logic [CFG_W-1:0] zero_trim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_limit_reg    <= WINDOW_LIMIT_RST;
            correction_step_reg <= CORRECTION_STEP_RST;
            zero_trim_reg       <= ZERO_TRIM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_LIMIT:    window_limit_reg    <= cfg_wdata;
                REG_CORRECTION_STEP: correction_step_reg <= cfg_wdata;
                REG_ZERO_TRIM:       zero_trim_reg       <= cfg_wdata;
                default:             ; // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage control
    // ------------------------------------------------------------------
    pipe_ctrl_t ctrl;
    logic [PIPE_STAGES-1:0] ld;

    vsad_pipe_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (duty_valid),
        .up_ready   (duty_ready),
        .down_ready (angle_ready),
        .ctrl       (ctrl)
    );

    assign ld          = ctrl.load;
    assign angle_valid = ctrl.valid[PIPE_STAGES-1];

    // ------------------------------------------------------------------
    // stage 1: saturate duties, gear angles, wrapped fine angle
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0]   df_sat;
    logic [DUTY_W-1:0]   dc_sat;
    logic [19:0]         w_pre;
    logic [23:0]         c_prod;
    logic [22:0]         r_prod;
    logic [18:0]         w1_reg, w1_next;          // wrapped fine angle, mdeg
    logic signed [23:0]  cterm1_reg, cterm1_next;  // -14 * coarse gear angle
    logic signed [22:0]  r1_reg, r1_next;          // coarse reference angle

    always_comb
    begin
        df_sat = (duty_fine > DUTY_FULL) ? DUTY_FULL : duty_fine;
        dc_sat = (duty_coarse > DUTY_FULL) ? DUTY_FULL : duty_coarse;
        // fine angle plus half a revolution: 48*d - 60000 + 180000
        w_pre = 20'(df_sat) * 20'd48 + 20'd120000;
        // below two revolutions, one subtract wraps it
        w1_next = (w_pre >= 20'd360000) ? 19'(w_pre - 20'd360000) : w_pre[18:0];
        // -14 * (48*dc - 60000)
        c_prod      = 24'(dc_sat) * 24'd672;
        cterm1_next = 24'sd840000 - $signed(c_prod);
        r_prod      = 23'(dc_sat) * 23'd232;
        r1_next     = $signed(r_prod) - 23'sd1160000;
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            w1_reg     <= w1_next;
            cterm1_reg <= cterm1_next;
            r1_reg     <= r1_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: vernier difference, magnitude plus half a revolution
    // ------------------------------------------------------------------
    logic signed [23:0] n2;
    logic [22:0]        mag2;
    logic [22:0]        m2;
    logic [16:0]        x2_reg, x2_next;
    logic               neg2_reg, neg2_next;
    logic [18:0]        w2_reg;
    logic signed [22:0] r2_reg;

    always_comb
    begin
        n2        = $signed({5'b0, w1_reg}) + cterm1_reg;
        mag2      = n2[23] ? 23'(-n2) : n2[22:0];
        m2        = mag2 + 23'd180000;
        // 360000 = 64 * 5625, drop the power of two first
        x2_next   = m2[22:6];
        neg2_next = n2[23];
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            x2_reg   <= x2_next;
            neg2_reg <= neg2_next;
            w2_reg   <= w1_reg;
            r2_reg   <= r1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: rounded revolution estimate by reciprocal multiply
    // ------------------------------------------------------------------
    logic [36:0]        prod3;
    logic [4:0]         q3_reg, q3_next;
    logic [21:0]        w6_3_reg, w6_3_next;
    logic               neg3_reg;
    logic signed [22:0] r3_reg;

    always_comb
    begin
        prod3     = 37'(x2_reg) * 37'(RECIP_REV);
        q3_next   = prod3[36:32];
        w6_3_next = 22'(w2_reg) * 22'd6;
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            q3_reg   <= q3_next;
            w6_3_reg <= w6_3_next;
            neg3_reg <= neg2_reg;
            r3_reg   <= r2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: turn index and vernier numerator
    // ------------------------------------------------------------------
    logic [TURN_W-1:0]  t4;
    logic [25:0]        num4;
    logic signed [25:0] nv4_reg, nv4_next;
    logic [TURN_W-1:0]  t4_reg;
    logic signed [22:0] r4_reg;

    always_comb
    begin
        // 13*k mod 14 equals -k mod 14
        if (!neg3_reg)
        begin
            t4 = (q3_reg == 5'd0) ? 4'd0 : 4'(5'd14 - q3_reg);
        end
        else
        begin
            t4 = (q3_reg >= 5'd14) ? 4'(q3_reg - 5'd14) : q3_reg[3:0];
        end
        num4     = 26'(t4) * 26'd2160000 + 26'(w6_3_reg);
        nv4_next = $signed(num4) - 26'sd15120000;
    end

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            nv4_reg <= nv4_next;
            t4_reg  <= t4;
            r4_reg  <= r3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: magnitude plus half of 17
    // ------------------------------------------------------------------
    logic [25:0]        abs5;
    logic [23:0]        a5_reg, a5_next;
    logic               sgn5_reg;
    logic [TURN_W-1:0]  t5_reg;
    logic signed [22:0] r5_reg;

    always_comb
    begin
        abs5    = nv4_reg[25] ? 26'(-nv4_reg) : 26'(nv4_reg);
        a5_next = 24'(abs5 + 26'd8);
    end

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            a5_reg   <= a5_next;
            sgn5_reg <= nv4_reg[25];
            t5_reg   <= t4_reg;
            r5_reg   <= r4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: divide by 17
    // ------------------------------------------------------------------
    logic [47:0]        prod6;
    logic [19:0]        q6_reg, q6_next;
    logic               sgn6_reg;
    logic [TURN_W-1:0]  t6_reg;
    logic signed [22:0] r6_reg;

    always_comb
    begin
        prod6   = 48'(a5_reg) * 48'(RECIP_17);
        q6_next = prod6[47:28];
    end

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            q6_reg   <= q6_next;
            sgn6_reg <= sgn5_reg;
            t6_reg   <= t5_reg;
            r6_reg   <= r5_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: signed vernier angle minus zero trim
    // ------------------------------------------------------------------
    logic signed [22:0] qs7;
    logic [22:0]        trim7;
    logic signed [22:0] u7_reg, u7_next;
    logic [TURN_W-1:0]  t7_reg;
    logic signed [22:0] r7_reg;

    always_comb
    begin
        qs7     = sgn6_reg ? -$signed({3'b0, q6_reg}) : $signed({3'b0, q6_reg});
        trim7   = 23'(zero_trim_reg) * 23'd10;
        u7_next = qs7 - $signed(trim7);
    end

    always_ff @(posedge clk)
    begin
        if (ld[6])
        begin
            u7_reg <= u7_next;
            t7_reg <= t6_reg;
            r7_reg <= r6_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: window test against the coarse reference
    // ------------------------------------------------------------------
    logic signed [23:0] diff8;
    logic [23:0]        win8;
    logic [FIX_W-1:0]   fix8_reg, fix8_next;
    logic signed [22:0] u8_reg;
    logic [TURN_W-1:0]  t8_reg;

    always_comb
    begin
        diff8 = $signed({u7_reg[22], u7_reg}) - $signed({r7_reg[22], r7_reg});
        win8  = 24'(window_limit_reg) * 24'd10;
        if (diff8 > $signed(win8))
        begin
            fix8_next = FIX_SUB;
        end
        else if (diff8 < -$signed(win8))
        begin
            fix8_next = FIX_ADD;
        end
        else
        begin
            fix8_next = FIX_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[7])
        begin
            fix8_reg <= fix8_next;
            u8_reg   <= u7_reg;
            t8_reg   <= t7_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: apply correction step
    // ------------------------------------------------------------------
    logic [22:0]        step9;
    logic signed [22:0] u9_reg, u9_next;
    logic [FIX_W-1:0]   fix9_reg;
    logic [TURN_W-1:0]  t9_reg;

    always_comb
    begin
        step9 = 23'(correction_step_reg) * 23'd10;
        case (fix8_reg)
            FIX_SUB: u9_next = u8_reg - $signed(step9);
            FIX_ADD: u9_next = u8_reg + $signed(step9);
            default: u9_next = u8_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld[8])
        begin
            u9_reg   <= u9_next;
            fix9_reg <= fix8_reg;
            t9_reg   <= t8_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 10: magnitude plus half of 10
    // ------------------------------------------------------------------
    logic [22:0]        abs10;
    logic [20:0]        a10_reg, a10_next;
    logic               sgn10_reg;
    logic [FIX_W-1:0]   fix10_reg;
    logic [TURN_W-1:0]  t10_reg;

    always_comb
    begin
        abs10    = u9_reg[22] ? 23'(-u9_reg) : 23'(u9_reg);
        a10_next = 21'(abs10 + 23'd5);
    end

    always_ff @(posedge clk)
    begin
        if (ld[9])
        begin
            a10_reg   <= a10_next;
            sgn10_reg <= u9_reg[22];
            fix10_reg <= fix9_reg;
            t10_reg   <= t9_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 11: divide by 10
    // ------------------------------------------------------------------
    logic [41:0]        prod11;
    logic [17:0]        q11_reg, q11_next;
    logic               sgn11_reg;
    logic [FIX_W-1:0]   fix11_reg;
    logic [TURN_W-1:0]  t11_reg;

    always_comb
    begin
        prod11   = 42'(a10_reg) * 42'(RECIP_10);
        q11_next = prod11[41:24];
    end

    always_ff @(posedge clk)
    begin
        if (ld[10])
        begin
            q11_reg   <= q11_next;
            sgn11_reg <= sgn10_reg;
            fix11_reg <= fix10_reg;
            t11_reg   <= t10_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 12: clamp, restore sign, output register
    // ------------------------------------------------------------------
    logic [17:0]                 mag12;
    logic signed [ANGLE_W-1:0]   angle12_reg, angle12_next;
    logic [FIX_W-1:0]            fix12_reg;
    logic [TURN_W-1:0]           t12_reg;

    always_comb
    begin
        mag12        = (q11_reg > OUT_MAX) ? OUT_MAX : q11_reg;
        angle12_next = sgn11_reg ? -$signed({1'b0, mag12}) : $signed({1'b0, mag12});
    end

    always_ff @(posedge clk)
    begin
        if (ld[11])
        begin
            angle12_reg <= angle12_next;
            fix12_reg   <= fix11_reg;
            t12_reg     <= t11_reg;
        end
    end

    assign steer_angle = angle12_reg;
    assign turn_index  = t12_reg;
    assign window_fix  = fix12_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // an accepted transaction always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid && duty_ready |=> ctrl.valid[0])
        else $error("accepted transaction not captured in first stage");

    // a full output stage that is not taken keeps its result
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && !angle_ready |=> angle_valid && $stable(steer_angle))
        else $error("stalled result lost or changed");

    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> turn_index <= 4'd13)
        else $error("turn index outside vernier range");

    a_fix_code: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (window_fix == FIX_NONE || window_fix == FIX_SUB ||
                         window_fix == FIX_ADD))
        else $error("window correction code undefined");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (steer_angle <= 19'sd140000 && steer_angle >= -19'sd140000))
        else $error("steering angle outside clamp range");

endmodule
